// ===== rtl/aabb_pkg.sv =====
// Shared types, constants and fixed-point helpers for the box boundary impulse block.
package aabb_pkg;

  localparam int DW = 32;          // data word width
  localparam int FB = 16;          // fraction bits
  localparam int PW = 2 * DW + 2;  // raw product width
  localparam int SW = DW + 2;      // sum width before clamping
  localparam int CW = 64;          // configuration data width
  localparam int IW = 4;           // configuration index width

  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
  localparam logic [17:0]          ONEQ = 18'(1 << FB);

  // Register indexes of the configuration port.
  typedef enum logic [IW-1:0] {
    REG_BOX_X    = 4'd0,
    REG_BOX_Y    = 4'd1,
    REG_BOX_Z    = 4'd2,
    REG_SCALE    = 4'd3,
    REG_RADIUS   = 4'd4,
    REG_GAIN     = 4'd5,
    REG_RESTIT   = 4'd6,
    REG_FRICTION = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0][CW-1:0] bounds;
    logic [30:0]        sim_scale;
    logic [30:0]        radius;
    logic [30:0]        gain;
    logic [16:0]        restit;
    logic [16:0]        fric;
  } cfg_t;

  // A clamped value and whether the clamp changed it.
  typedef struct packed {
    logic [DW-1:0] v;
    logic          s;
  } q_t;

  // Face products after scaling, handed from the distance unit.
  typedef struct packed {
    logic [2:0][DW-1:0] vel;
    logic [5:0]         pen;
    logic [5:0][DW-1:0] negd;
    logic [5:0][DW-1:0] qm;
    logic [5:0][DW-1:0] qt;
    logic [2:0][DW-1:0] qv;
    logic [5:0]         fsat;
    logic [2:0]         vsat;
    logic               sat;
  } dist_t;

  // Per-face impulses along the face normal, handed to the accumulator.
  typedef struct packed {
    logic [2:0][DW-1:0] vel;
    logic [5:0]         pen;
    logic [5:0][DW-1:0] along;
    logic [2:0][DW-1:0] qv;
    logic               sat;
  } imp_t;

  // Sign extension of a data word to sum width.
  function automatic logic signed [SW-1:0] sx(input logic signed [DW-1:0] x);
    return SW'(x);
  endfunction

  // Floor shift of a raw product by the fraction bits, then clamp.
  function automatic q_t mul_shift(input logic signed [PW-1:0] prod);
    logic signed [PW-1:0] sh;
    q_t r;
    sh = prod >>> FB;
    if (sh[PW-1:DW-1] == '0 || sh[PW-1:DW-1] == '1) begin
      r.v = sh[DW-1:0];
      r.s = 1'b0;
    end else if (sh[PW-1]) begin
      r.v = MINV;
      r.s = 1'b1;
    end else begin
      r.v = MAXV;
      r.s = 1'b1;
    end
    return r;
  endfunction

  // Clamp a wide sum to the data range.
  function automatic q_t sat_add(input logic signed [SW-1:0] x);
    q_t r;
    if (x[SW-1:DW-1] == '0 || x[SW-1:DW-1] == '1) begin
      r.v = x[DW-1:0];
      r.s = 1'b0;
    end else if (x[SW-1]) begin
      r.v = MINV;
      r.s = 1'b1;
    end else begin
      r.v = MAXV;
      r.s = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/aabb_dist.sv =====
// Face distances, inward speeds and all products that depend only on the input word.
module aabb_dist import aabb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0][DW-1:0] pos_i,
  input  logic [2:0][DW-1:0] vel_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dist_t              out_o
);

  typedef struct packed {
    logic [5:0][DW:0]   diff;
    logic [2:0][DW-1:0] vel;
    logic [5:0][DW-1:0] m;
    logic [5:0][DW-1:0] t;
    logic [5:0]         msat;
  } s1_t;

  typedef struct packed {
    logic [5:0][PW-1:0] pd;
    logic [5:0][PW-1:0] pm;
    logic [5:0][PW-1:0] pt;
    logic [2:0][PW-1:0] pv;
    logic [2:0][DW-1:0] vel;
    logic [5:0]         msat;
  } s2_t;

  s1_t   s1_d, s1_q;
  s2_t   s2_d, s2_q;
  dist_t s3_d, s3_q;
  logic  v1_q, v2_q, v3_q;
  logic  en1, en2, en3;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o  = en1;
  assign out_valid_o = v3_q;
  assign out_o       = s3_q;

  // Stage one: signed distances to each face and the inward speed.
  always_comb begin
    logic signed [DW-1:0] lo, hi, p, v;
    logic signed [SW-1:0] x;
    q_t mc;
    s1_d = '0;
    for (int f = 0; f < 6; f++) begin
      lo = cfg_i.bounds[f >> 1][DW-1:0];
      hi = cfg_i.bounds[f >> 1][2*DW-1:DW];
      p  = pos_i[f >> 1];
      v  = vel_i[f >> 1];
      if ((f & 1) == 0) begin
        s1_d.diff[f] = (DW+1)'(sx(p) - sx(lo));
        x = -sx(v);
      end else begin
        s1_d.diff[f] = (DW+1)'(sx(hi) - sx(p));
        x = sx(v);
      end
      if (x[SW-1]) begin
        mc = '0;
      end else begin
        mc = sat_add(x);
      end
      s1_d.m[f]    = mc.v;
      s1_d.msat[f] = mc.s;
      if ((f & 1) == 0) begin
        s1_d.t[f] = DW'(sx(v) + sx(mc.v));
      end else begin
        s1_d.t[f] = DW'(sx(v) - sx(mc.v));
      end
    end
    s1_d.vel = vel_i;
  end

  // Stage two: raw products.
  always_comb begin
    logic [17:0] rf;
    rf = ONEQ + {1'b0, cfg_i.restit};
    s2_d = '0;
    for (int f = 0; f < 6; f++) begin
      s2_d.pd[f] = $signed(s1_q.diff[f]) * $signed({1'b0, cfg_i.sim_scale});
      s2_d.pm[f] = $signed({1'b0, s1_q.m[f]}) * $signed({1'b0, rf});
      s2_d.pt[f] = $signed(s1_q.t[f]) * $signed({1'b0, cfg_i.fric});
    end
    for (int b = 0; b < 3; b++) begin
      s2_d.pv[b] = $signed(s1_q.vel[b]) * $signed({1'b0, cfg_i.fric});
    end
    s2_d.vel  = s1_q.vel;
    s2_d.msat = s1_q.msat;
  end

  // Stage three: scale products back, test penetration.
  always_comb begin
    q_t qd, qm, qt, qv;
    logic signed [DW:0] d;
    s3_d = '0;
    for (int f = 0; f < 6; f++) begin
      qd = mul_shift(s2_q.pd[f]);
      qm = mul_shift(s2_q.pm[f]);
      qt = mul_shift(s2_q.pt[f]);
      d  = $signed({qd.v[DW-1], qd.v}) - $signed({2'b00, cfg_i.radius});
      s3_d.pen[f]  = d[DW];
      s3_d.negd[f] = DW'(-d);
      s3_d.qm[f]   = qm.v;
      s3_d.qt[f]   = qt.v;
      s3_d.fsat[f] = s2_q.msat[f] | qm.s | qt.s;
      s3_d.sat     = s3_d.sat | qd.s;
    end
    for (int b = 0; b < 3; b++) begin
      qv = mul_shift(s2_q.pv[b]);
      s3_d.qv[b]   = qv.v;
      s3_d.vsat[b] = qv.s;
    end
    s3_d.vel = s2_q.vel;
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) s1_q <= s1_d;
    if (en2 && v1_q) s2_q <= s2_d;
    if (en3 && v2_q) s3_q <= s3_d;
  end

endmodule

// ===== rtl/aabb_impulse.sv =====
// Position correction and the normal impulse of each face.
module aabb_impulse import aabb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  dist_t in_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output imp_t  out_o
);

  typedef struct packed {
    dist_t              d;
    logic [5:0][PW-1:0] pc;
  } s4_t;

  s4_t  s4_d, s4_q;
  imp_t s5_d, s5_q;
  logic v4_q, v5_q;
  logic en4, en5;

  assign en5 = !v5_q || out_ready_i;
  assign en4 = !v4_q || en5;
  assign in_ready_o  = en4;
  assign out_valid_o = v5_q;
  assign out_o       = s5_q;

  // Correction product: penetration depth times gain.
  always_comb begin
    s4_d.d = in_i;
    for (int f = 0; f < 6; f++) begin
      s4_d.pc[f] = PW'((PW-1)'({1'b0, in_i.negd[f]}) * (PW-1)'({1'b0, cfg_i.gain}));
    end
  end

  // Normal impulse per face; unpenetrated faces give nothing.
  always_comb begin
    q_t corr, a1, a2;
    logic [DW-1:0] along;
    logic fs;
    s5_d = '0;
    s5_d.vel = s4_q.d.vel;
    s5_d.qv  = s4_q.d.qv;
    s5_d.pen = s4_q.d.pen;
    s5_d.sat = s4_q.d.sat;
    for (int f = 0; f < 6; f++) begin
      corr = mul_shift(s4_q.pc[f]);
      a1   = sat_add(sx(s4_q.d.qm[f]) + sx(corr.v));
      along = ((f & 1) == 0) ? a1.v : DW'(-a1.v);
      a2   = sat_add(sx(along) - sx(s4_q.d.qt[f]));
      fs   = corr.s | a1.s | a2.s | s4_q.d.fsat[f];
      for (int b = 0; b < 3; b++) begin
        if (b != (f >> 1)) fs = fs | s4_q.d.vsat[b];
      end
      if (s4_q.d.pen[f]) begin
        s5_d.along[f] = a2.v;
        s5_d.sat      = s5_d.sat | fs;
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en4) v4_q <= in_valid_i;
      if (en5) v5_q <= v4_q;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk_i) begin
    if (en4 && in_valid_i) s4_q <= s4_d;
    if (en5 && v4_q) s5_q <= s5_d;
  end

endmodule

// ===== rtl/aabb_accum.sv =====
// Ordered, clamped impulse sum over the six faces and the velocity update.
module aabb_accum import aabb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  imp_t               in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0][DW-1:0] next_vel_o,
  output logic [2:0][DW-1:0] mid_vel_o,
  output logic               sat_o
);

  typedef struct packed {
    imp_t               w;
    logic [2:0][DW-1:0] imp;
  } acc_t;

  typedef struct packed {
    logic [2:0][DW-1:0] nx;
    logic [2:0][DW-1:0] mid;
    logic               sat;
  } res_t;

  acc_t s6_d, s6_q, s7_d, s7_q;
  res_t s8_d, s8_q;
  logic v6_q, v7_q, v8_q;
  logic en6, en7, en8;

  assign en8 = !v8_q || out_ready_i;
  assign en7 = !v7_q || en8;
  assign en6 = !v6_q || en7;
  assign in_ready_o  = en6;
  assign out_valid_o = v8_q;
  assign next_vel_o  = s8_q.nx;
  assign mid_vel_o   = s8_q.mid;
  assign sat_o       = s8_q.sat;

  // Faces min x, max x, min y, starting from a zero sum.
  always_comb begin
    logic signed [SW-1:0] c;
    q_t r;
    s6_d.w   = in_i;
    s6_d.imp = '0;
    for (int f = 0; f < 3; f++) begin
      for (int b = 0; b < 3; b++) begin
        if (!in_i.pen[f]) c = '0;
        else if (b == (f >> 1)) c = sx(in_i.along[f]);
        else c = -sx(in_i.qv[b]);
        r = sat_add(sx(s6_d.imp[b]) + c);
        s6_d.imp[b] = r.v;
        s6_d.w.sat  = s6_d.w.sat | r.s;
      end
    end
  end

  // Faces max y, min z, max z.
  always_comb begin
    logic signed [SW-1:0] c;
    q_t r;
    s7_d = s6_q;
    for (int f = 3; f < 6; f++) begin
      for (int b = 0; b < 3; b++) begin
        if (!s6_q.w.pen[f]) c = '0;
        else if (b == (f >> 1)) c = sx(s6_q.w.along[f]);
        else c = -sx(s6_q.w.qv[b]);
        r = sat_add(sx(s7_d.imp[b]) + c);
        s7_d.imp[b] = r.v;
        s7_d.w.sat  = s7_d.w.sat | r.s;
      end
    end
  end

  // New velocity and the leapfrog midpoint.
  always_comb begin
    q_t r;
    logic signed [SW-1:0] sum;
    s8_d.sat = s7_q.w.sat;
    for (int b = 0; b < 3; b++) begin
      r = sat_add(sx(s7_q.w.vel[b]) + sx(s7_q.imp[b]));
      sum = sx(s7_q.w.vel[b]) + sx(r.v);
      s8_d.nx[b]  = r.v;
      s8_d.mid[b] = sum[DW:1];
      s8_d.sat    = s8_d.sat | r.s;
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      if (en6) v6_q <= in_valid_i;
      if (en7) v7_q <= v6_q;
      if (en8) v8_q <= v7_q;
    end
  end

  // Stage payload registers; the last one is the output word.
  always_ff @(posedge clk_i) begin
    if (en6 && in_valid_i) s6_q <= s6_d;
    if (en7 && v6_q) s7_q <= s7_d;
    if (en8 && v7_q) s8_q <= s8_d;
  end

endmodule

// ===== rtl/aabb_boundary_impulse_integrate.sv =====
// Top level: configuration registers and the eight-stage boundary impulse pipeline.
// Throughput is one word per cycle while the output is not stalled;
// each stage holds at most one multiply or clamped add chain.
// Stages hand words on independently, so bubbles close up while the output is stalled.
// Reset clears all valid bits and sets every configuration register to zero except sim_scale (1.0).
module aabb_boundary_impulse_integrate import aabb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [IW-1:0] cfg_index_i,
  input  logic [CW-1:0] cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [DW-1:0] pos_x_i,
  input  logic [DW-1:0] pos_y_i,
  input  logic [DW-1:0] pos_z_i,
  input  logic [DW-1:0] vel_x_i,
  input  logic [DW-1:0] vel_y_i,
  input  logic [DW-1:0] vel_z_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [DW-1:0] next_vel_x_o,
  output logic [DW-1:0] next_vel_y_o,
  output logic [DW-1:0] next_vel_z_o,
  output logic [DW-1:0] mid_vel_x_o,
  output logic [DW-1:0] mid_vel_y_o,
  output logic [DW-1:0] mid_vel_z_o,
  output logic          saturated_o
);

  cfg_t  cfg_q;
  dist_t dist_w;
  imp_t  imp_w;
  logic  in_ready, dist_valid, imp_ready, imp_valid, acc_ready;
  logic [2:0][DW-1:0] next_vel, mid_vel;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bounds    <= '0;
      cfg_q.sim_scale <= 31'(1 << FB);
      cfg_q.radius    <= '0;
      cfg_q.gain      <= '0;
      cfg_q.restit    <= '0;
      cfg_q.fric      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BOX_X:    cfg_q.bounds[0] <= cfg_data_i;
        REG_BOX_Y:    cfg_q.bounds[1] <= cfg_data_i;
        REG_BOX_Z:    cfg_q.bounds[2] <= cfg_data_i;
        REG_SCALE:    cfg_q.sim_scale <= cfg_data_i[30:0];
        REG_RADIUS:   cfg_q.radius    <= cfg_data_i[30:0];
        REG_GAIN:     cfg_q.gain      <= cfg_data_i[30:0];
        REG_RESTIT:   cfg_q.restit    <= cfg_data_i[16:0];
        REG_FRICTION: cfg_q.fric      <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = !in_ready;

  aabb_dist u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .pos_i       ({pos_z_i, pos_y_i, pos_x_i}),
    .vel_i       ({vel_z_i, vel_y_i, vel_x_i}),
    .out_valid_o (dist_valid),
    .out_ready_i (imp_ready),
    .out_o       (dist_w)
  );

  aabb_impulse u_impulse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (dist_valid),
    .in_ready_o  (imp_ready),
    .in_i        (dist_w),
    .out_valid_o (imp_valid),
    .out_ready_i (acc_ready),
    .out_o       (imp_w)
  );

  aabb_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (imp_valid),
    .in_ready_o  (acc_ready),
    .in_i        (imp_w),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .next_vel_o  (next_vel),
    .mid_vel_o   (mid_vel),
    .sat_o       (saturated_o)
  );

  assign next_vel_x_o = next_vel[0];
  assign next_vel_y_o = next_vel[1];
  assign next_vel_z_o = next_vel[2];
  assign mid_vel_x_o  = mid_vel[0];
  assign mid_vel_y_o  = mid_vel[1];
  assign mid_vel_z_o  = mid_vel[2];

endmodule

// ===== bench/aabb_checker.sv =====
// Checker for the box boundary impulse block: predicts each output word and compares it.
`timescale 1ns / 1ps
module aabb_checker import aabb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [IW-1:0] cfg_index_i,
  input  logic [CW-1:0] cfg_data_i,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  logic [DW-1:0] pos_x_i,
  input  logic [DW-1:0] pos_y_i,
  input  logic [DW-1:0] pos_z_i,
  input  logic [DW-1:0] vel_x_i,
  input  logic [DW-1:0] vel_y_i,
  input  logic [DW-1:0] vel_z_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  logic [DW-1:0] next_vel_x_i,
  input  logic [DW-1:0] next_vel_y_i,
  input  logic [DW-1:0] next_vel_z_i,
  input  logic [DW-1:0] mid_vel_x_i,
  input  logic [DW-1:0] mid_vel_y_i,
  input  logic [DW-1:0] mid_vel_z_i,
  input  logic          saturated_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            results_o
);

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [2:0][DW-1:0] next_vel;
    logic [2:0][DW-1:0] mid_vel;
    logic               sat;
  } velocity_word_t;

  // Shadow copy of the block's registers.
  logic [2:0][CW-1:0] box_bounds;
  wide_t              scale, radius, gain, restit, fric;

  velocity_word_t expected_words[$];

  int fails = 0;
  int seen  = 0;

  // Clamp to the data range, noting whether the value changed.
  function automatic wide_t clamp_q(input wide_t x, inout bit sat);
    if (x > wide_t'(MAXV)) begin
      sat = 1'b1;
      return wide_t'(MAXV);
    end
    if (x < wide_t'(MINV)) begin
      sat = 1'b1;
      return wide_t'(MINV);
    end
    return x;
  endfunction

  // Fixed-point product, floored, then clamped.
  function automatic wide_t mul_q(input wide_t a, input wide_t b, inout bit sat);
    wide_t p;
    p = (a * b) >>> FB;
    return clamp_q(p, sat);
  endfunction

  // Full impulse and leapfrog update for one particle.
  function automatic velocity_word_t predict_velocity(input logic [2:0][DW-1:0] pos,
                                                      input logic [2:0][DW-1:0] vel);
    velocity_word_t w;
    wide_t p[3], v[3], imp[3];
    wide_t lo, hi, diff, d, corr, m, t, along, c, nx;
    bit sat;
    sat = 1'b0;
    for (int a = 0; a < 3; a++) begin
      p[a] = wide_t'($signed(pos[a]));
      v[a] = wide_t'($signed(vel[a]));
      imp[a] = '0;
    end
    for (int a = 0; a < 3; a++) begin
      lo = wide_t'($signed(box_bounds[a][31:0]));
      hi = wide_t'($signed(box_bounds[a][63:32]));
      for (int side = 0; side < 2; side++) begin
        diff = (side == 0) ? p[a] - lo : hi - p[a];
        d = mul_q(diff, scale, sat) - radius;
        if (d < 0) begin
          corr = mul_q(-d, gain, sat);
          m = (side == 0) ? -v[a] : v[a];
          if (m < 0) m = '0;
          m = clamp_q(m, sat);
          t = clamp_q((side == 0) ? v[a] + m : v[a] - m, sat);
          along = clamp_q(mul_q(m, wide_t'(65536) + restit, sat) + corr, sat);
          if (side != 0) along = -along;
          along = clamp_q(along - mul_q(t, fric, sat), sat);
          for (int b = 0; b < 3; b++) begin
            c = (b == a) ? along : -mul_q(v[b], fric, sat);
            imp[b] = clamp_q(imp[b] + c, sat);
          end
        end
      end
    end
    for (int a = 0; a < 3; a++) begin
      nx = clamp_q(v[a] + imp[a], sat);
      w.next_vel[a] = nx[DW-1:0];
      c = (v[a] + nx) >>> 1;
      w.mid_vel[a] = c[DW-1:0];
    end
    w.sat = sat;
    return w;
  endfunction

  // One line per mismatch, and a running count.
  task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fails++;
  endtask

  assign fail_count_o = fails;
  assign results_o    = seen;
  assign pending_o    = expected_words.size();

  // Track registers, queue expectations and check output words.
  always @(posedge clk_i or negedge rst_ni) begin
    velocity_word_t got, want;
    if (!rst_ni) begin
      box_bounds <= '0;
      scale      <= wide_t'(65536);
      radius     <= '0;
      gain       <= '0;
      restit     <= '0;
      fric       <= '0;
      expected_words.delete();
    end else begin
      if (in_valid_i && !in_stall_i)
        expected_words.insert(expected_words.size(),
                              predict_velocity({pos_z_i, pos_y_i, pos_x_i},
                                               {vel_z_i, vel_y_i, vel_x_i}));
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_BOX_X:    box_bounds[0] <= cfg_data_i;
          REG_BOX_Y:    box_bounds[1] <= cfg_data_i;
          REG_BOX_Z:    box_bounds[2] <= cfg_data_i;
          REG_SCALE:    scale  <= wide_t'(cfg_data_i[30:0]);
          REG_RADIUS:   radius <= wide_t'(cfg_data_i[30:0]);
          REG_GAIN:     gain   <= wide_t'(cfg_data_i[30:0]);
          REG_RESTIT:   restit <= wide_t'(cfg_data_i[16:0]);
          REG_FRICTION: fric   <= wide_t'(cfg_data_i[16:0]);
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        seen++;
        got.next_vel = {next_vel_z_i, next_vel_y_i, next_vel_x_i};
        got.mid_vel  = {mid_vel_z_i, mid_vel_y_i, mid_vel_x_i};
        got.sat      = saturated_i;
        if (expected_words.size() == 0) begin
          $display("%0t: output word with nothing expected", $realtime);
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (got.next_vel[0] !== want.next_vel[0])
            report_mismatch("next_vel_x", got.next_vel[0], want.next_vel[0]);
          if (got.next_vel[1] !== want.next_vel[1])
            report_mismatch("next_vel_y", got.next_vel[1], want.next_vel[1]);
          if (got.next_vel[2] !== want.next_vel[2])
            report_mismatch("next_vel_z", got.next_vel[2], want.next_vel[2]);
          if (got.mid_vel[0] !== want.mid_vel[0])
            report_mismatch("mid_vel_x", got.mid_vel[0], want.mid_vel[0]);
          if (got.mid_vel[1] !== want.mid_vel[1])
            report_mismatch("mid_vel_y", got.mid_vel[1], want.mid_vel[1]);
          if (got.mid_vel[2] !== want.mid_vel[2])
            report_mismatch("mid_vel_z", got.mid_vel[2], want.mid_vel[2]);
          if (got.sat !== want.sat)
            report_mismatch("saturated", DW'(got.sat), DW'(want.sat));
        end
      end
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top: drives particles and register writes, and gives the verdict.
`timescale 1ns / 1ps
module tb_top import aabb_pkg::*; ();

  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 118;
  localparam int STALL_LIMIT = 3000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [IW-1:0] cfg_index_i = '0;
  logic [CW-1:0] cfg_data_i = '0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  logic [DW-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [DW-1:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b1;
  logic [DW-1:0] next_vel_x_o, next_vel_y_o, next_vel_z_o;
  logic [DW-1:0] mid_vel_x_o, mid_vel_y_o, mid_vel_z_o;
  logic          saturated_o;
  int            fail_count, pending, results;
  bit            steady;
  int            words_sent;
  int            idle_cycles = 0;
  int            drain_wait;
  logic [2:0][CW-1:0] box_now;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  aabb_boundary_impulse_integrate uut (.*);

  aabb_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o),
    .pos_x_i, .pos_y_i, .pos_z_i, .vel_x_i, .vel_y_i, .vel_z_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .next_vel_x_i(next_vel_x_o), .next_vel_y_i(next_vel_y_o),
    .next_vel_z_i(next_vel_z_o), .mid_vel_x_i(mid_vel_x_o),
    .mid_vel_y_i(mid_vel_y_o), .mid_vel_z_i(mid_vel_z_o),
    .saturated_i(saturated_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results)
  );

  // Receiver: stalls a random number of cycles before taking each word, except in steady mode.
  always @(posedge clk_i) begin
    int hold;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        hold = steady ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout with %0d words outstanding.", pending);
      $display("tb_top failed");
      $finish;
    end
  end

  // One register write; the caller drops the write enable after the last one.
  task automatic write_reg(input cfg_reg_e idx, input logic [CW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
  endtask

  // Hold off the sender until every predicted word has come back.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic send_particle(input logic [DW-1:0] px, py, pz, vx, vy, vz);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= px; pos_y_i <= py; pos_z_i <= pz;
    vel_x_i <= vx; vel_y_i <= vy; vel_z_i <= vz;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  // A coordinate mostly near a box face, sometimes anywhere.
  function automatic logic [DW-1:0] near_face(input logic [CW-1:0] bounds);
    logic [DW-1:0] face;
    logic [DW-1:0] off;
    face = $urandom_range(0, 1) ? bounds[63:32] : bounds[31:0];
    off  = $urandom_range(0, 32'h0004_0000);
    case ($urandom_range(0, 3))
      0: return face + off;
      1: return face - off;
      2: return face;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DW-1:0] rand_velocity();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? MAXV - $urandom_range(0, 3) : MINV + $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic logic [CW-1:0] rand_box();
    logic signed [31:0] lo, hi;
    lo = -$signed($urandom_range(0, 32'h0100_0000));
    hi = $urandom_range(0, 32'h0100_0000);
    if ($urandom_range(0, 7) == 0) return {lo, hi};
    return {hi, lo};
  endfunction

  // Register settings per phase: none written in phase 0, then extremes, zero scale and gain, then random.
  task automatic configure_phase(input int ph);
    logic [CW-1:0] bx, by, bz;
    case (ph)
      0: begin
        box_now = '0;
      end
      1: begin
        bx = {32'h7FFF_FFFF, 32'h8000_0000};
        by = {32'h8000_0000, 32'h7FFF_FFFF};
        bz = '1;
        write_reg(REG_BOX_X, bx);
        write_reg(REG_BOX_Y, by);
        write_reg(REG_BOX_Z, bz);
        write_reg(REG_SCALE, 64'h7FFF_FFFF);
        write_reg(REG_RADIUS, 64'h7FFF_FFFF);
        write_reg(REG_GAIN, 64'h7FFF_FFFF);
        write_reg(REG_RESTIT, 64'h1_FFFF);
        write_reg(REG_FRICTION, 64'h1_FFFF);
        box_now = {bz, by, bx};
      end
      2: begin
        bx = {32'hFFFF_0000, 32'h0001_0000};
        by = {32'h0010_0000, 32'hFFF0_0000};
        bz = {32'h0000_0000, 32'h0000_0000};
        write_reg(REG_BOX_X, bx);
        write_reg(REG_BOX_Y, by);
        write_reg(REG_BOX_Z, bz);
        write_reg(REG_SCALE, '0);
        write_reg(REG_RADIUS, '0);
        write_reg(REG_GAIN, '0);
        write_reg(REG_RESTIT, 64'h1_0000);
        write_reg(REG_FRICTION, 64'h1_0000);
        box_now = {bz, by, bx};
      end
      default: begin
        bx = rand_box();
        by = rand_box();
        bz = rand_box();
        write_reg(REG_BOX_X, bx);
        write_reg(REG_BOX_Y, by);
        write_reg(REG_BOX_Z, bz);
        write_reg(REG_SCALE, $urandom_range(0, 3) == 0 ? {$urandom, $urandom}
                                                       : 64'($urandom_range(0, 32'h0004_0000)));
        write_reg(REG_RADIUS, 64'($urandom_range(0, 32'h0008_0000)));
        write_reg(REG_GAIN, $urandom_range(0, 1) ? {$urandom, $urandom}
                                                 : 64'($urandom_range(0, 32'h0010_0000)));
        write_reg(REG_RESTIT, 64'($urandom_range(0, 32'h1_0000)));
        write_reg(REG_FRICTION, 64'($urandom_range(0, 32'h1_0000)));
        box_now = {bz, by, bx};
      end
    endcase
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    steady = 1'b0;
    words_sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at reset defaults: field extremes and a stationary particle.
    send_particle('0, '0, '0, '0, '0, '0);
    send_particle(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
    send_particle(MINV, MINV, MINV, MINV, MINV, MINV);
    send_particle(MAXV, MINV, '0, MINV, MAXV, '1);
    send_particle('1, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'hFFFE_0000, '0);
    drain_pipeline();
    configure_phase(1);
    send_particle('0, '0, '0, MINV, MAXV, 32'h0001_0000);
    send_particle(MINV, MAXV, MINV, MAXV, MINV, MINV);
    send_particle(MAXV, MINV, MAXV, MINV, MINV, MAXV);
    drain_pipeline();
    configure_phase(2);
    send_particle(32'h0000_8000, '0, '0, 32'h0001_0000, '0, 32'hFFFF_0000);
    send_particle(MAXV, MINV, MAXV, 32'h0003_0000, MINV, MAXV);
    drain_pipeline();

    // Random phases; each phase but phase 0 writes its own register setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      configure_phase(ph);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        steady = (ph == 4) || (ph == 6 && n < 40);
        if (n == PHASE_WORDS / 2 && ph == 5) drain_pipeline();
        send_particle(near_face(box_now[0]), near_face(box_now[1]), near_face(box_now[2]),
                      rand_velocity(), rand_velocity(), rand_velocity());
      end
      drain_pipeline();
    end
    steady = 1'b0;

    drain_wait = 0;
    while (pending != 0 && drain_wait < 1000) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (20) @(posedge clk_i);
    $display("Sent %0d particles over %0d register settings, %0d velocity words checked.",
             words_sent, PHASES + 2, results);
    $display("Words left unanswered: %0d, mismatches: %0d.", pending, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
